/* src/brq_pkg.sv */
// Shared types, constants and pointer helpers for the byte ring queue.
`timescale 1ns / 1ps

package brq_pkg;

  // Storage slots; one slot always stays empty.
  localparam int unsigned DEPTH = 1024;
  localparam int unsigned PTR_W = $clog2(DEPTH);

  // Fixed field widths of the transaction payload.
  localparam int unsigned CMD_W = 3;
  localparam int unsigned CNT_W = 10;
  localparam int unsigned VAL_W = 64;
  localparam int unsigned BYTE_W = 8;

  // Widest move of one put, get or peek, in bytes.
  localparam int unsigned MAX_MOVE = 8;

  // Compare width that holds both a count and a fill level.
  localparam int unsigned CMP_W = ((CNT_W > PTR_W) ? CNT_W : PTR_W) + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT     = 3'd0,
    CMD_GET     = 3'd1,
    CMD_PEEK    = 3'd2,
    CMD_PEEK_AT = 3'd3,
    CMD_SKIP    = 3'd4,
    CMD_CLEAR   = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_WRITE,
    ST_READ,
    ST_DRAIN,
    ST_OUTPUT
  } state_e;

  // Slot that lies ahead bytes past base, wrapping at DEPTH. Needs ahead < DEPTH.
  function automatic logic [PTR_W-1:0] slot(input logic [PTR_W-1:0] base,
                                            input logic [PTR_W-1:0] ahead);
    logic [PTR_W:0] sum;
    sum = {1'b0, base} + {1'b0, ahead};
    if (sum >= (PTR_W+1)'(DEPTH)) begin
      sum = sum - (PTR_W+1)'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  // Bytes stored between the read and the write pointer.
  function automatic logic [PTR_W-1:0] fill_of(input logic [PTR_W-1:0] wp,
                                               input logic [PTR_W-1:0] rp);
    logic [PTR_W:0] diff;
    diff = {1'b0, wp} - {1'b0, rp};
    if (wp < rp) begin
      diff = diff + (PTR_W+1)'(DEPTH);
    end
    return diff[PTR_W-1:0];
  endfunction

endpackage

/* src/byte_ring_queue_big_endian.sv */
// Top level of the byte ring queue with big-endian multi-byte put, get and peek.
// Flow: an accepted transaction passes a decide state, then for a put the write loop, or for a
// get, peek or peek at offset the read loop and its drain state, and then the output state;
// skip, clear, failures and zero counts go straight from decide to output.
// Transactions: one at a time, set by the byte-wide storage port that moves one byte per
// cycle; the next input can be taken in the cycle after the result is taken.
// Reset: asynchronous, active low; both pointers go to zero, storage is untouched.
`timescale 1ns / 1ps

module byte_ring_queue_big_endian (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Input channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [brq_pkg::CMD_W-1:0]   command_i,
  input  logic [brq_pkg::CNT_W-1:0]   count_i,
  input  logic [brq_pkg::VAL_W-1:0]   value_i,
  input  logic [brq_pkg::CNT_W-1:0]   offset_i,
  // Result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        ok_o,
  output logic [brq_pkg::VAL_W-1:0]   data_o,
  output logic [brq_pkg::CNT_W-1:0]   fill_level_o,
  output logic [brq_pkg::CNT_W-1:0]   space_left_o
);

  localparam int unsigned PW = brq_pkg::PTR_W;
  localparam int unsigned CW = brq_pkg::CMP_W;
  localparam int unsigned BW = brq_pkg::BYTE_W;
  localparam int unsigned VW = brq_pkg::VAL_W;

  // Sequencer state and the latched transaction.
  brq_pkg::state_e             state_q, state_d;
  logic [brq_pkg::CMD_W-1:0]   cmd_q;
  logic [brq_pkg::CNT_W-1:0]   cnt_q;
  logic [brq_pkg::CNT_W-1:0]   offset_q;
  logic [VW-1:0]               value_q, value_d;

  // Queue pointers.
  logic [PW-1:0]               rp_q, rp_d;
  logic [PW-1:0]               wp_q, wp_d;

  // Byte loop: running storage address, byte index and number of bytes to move.
  logic [PW-1:0]               addr_q, addr_d;
  logic [2:0]                  idx_q, idx_d;
  logic [3:0]                  n_q, n_d;
  logic                        last_byte;

  // Read side: a read issued last cycle has its byte on the RAM output now.
  logic                        rd_pend_q, rd_pend_d;
  logic [VW-1:0]               acc_q, acc_d;
  logic                        ok_q, ok_d;

  // Storage port.
  logic                        ram_we;
  logic [BW-1:0]               ram_rdata;

  // Occupancy, derived from the pointers at all times.
  logic [PW-1:0]               fill;
  logic [PW-1:0]               space;
  logic [CW-1:0]               fill_x, space_x, cnt_x, off_x;
  logic                        cnt_fits;

  assign fill    = brq_pkg::fill_of(wp_q, rp_q);
  assign space   = PW'(brq_pkg::DEPTH - 1) - fill;
  assign fill_x  = CW'(fill);
  assign space_x = CW'(space);
  assign cnt_x   = CW'(cnt_q);
  assign off_x   = CW'(offset_q);
  assign cnt_fits = (cnt_q <= brq_pkg::CNT_W'(brq_pkg::MAX_MOVE));

  assign last_byte = ({1'b0, idx_q} == (n_q - 4'd1));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      brq_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = brq_pkg::ST_DECIDE;
        end
      end
      brq_pkg::ST_DECIDE: begin
        state_d = brq_pkg::ST_OUTPUT;
        unique case (cmd_q)
          brq_pkg::CMD_PUT: begin
            if (cnt_fits && (cnt_x <= space_x) && (cnt_q != '0)) begin
              state_d = brq_pkg::ST_WRITE;
            end
          end
          brq_pkg::CMD_GET, brq_pkg::CMD_PEEK: begin
            if (cnt_fits && (cnt_x <= fill_x) && (cnt_q != '0)) begin
              state_d = brq_pkg::ST_READ;
            end
          end
          brq_pkg::CMD_PEEK_AT: begin
            if (off_x < fill_x) begin
              state_d = brq_pkg::ST_READ;
            end
          end
          default: begin
            state_d = brq_pkg::ST_OUTPUT;
          end
        endcase
      end
      brq_pkg::ST_WRITE: begin
        if (last_byte) begin
          state_d = brq_pkg::ST_OUTPUT;
        end
      end
      brq_pkg::ST_READ: begin
        if (last_byte) begin
          state_d = brq_pkg::ST_DRAIN;
        end
      end
      brq_pkg::ST_DRAIN: begin
        state_d = brq_pkg::ST_OUTPUT;
      end
      brq_pkg::ST_OUTPUT: begin
        if (!out_stall_i) begin
          state_d = brq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = brq_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath and storage control for each state.
  always_comb begin
    rp_d      = rp_q;
    wp_d      = wp_q;
    addr_d    = addr_q;
    idx_d     = idx_q;
    n_d       = n_q;
    value_d   = value_q;
    acc_d     = acc_q;
    ok_d      = ok_q;
    rd_pend_d = 1'b0;
    ram_we    = 1'b0;

    // A byte read in the previous cycle shifts in as the new least significant byte.
    if (rd_pend_q) begin
      acc_d = {acc_q[VW-BW-1:0], ram_rdata};
    end

    unique case (state_q)
      brq_pkg::ST_IDLE: begin
        value_d = value_i;
      end
      brq_pkg::ST_DECIDE: begin
        ok_d  = 1'b0;
        acc_d = '0;
        idx_d = '0;
        n_d   = cnt_q[3:0];
        unique case (cmd_q)
          brq_pkg::CMD_PUT: begin
            if (cnt_fits && (cnt_x <= space_x)) begin
              ok_d   = 1'b1;
              addr_d = wp_q;
              // Left-justify the bytes to send so the first one sits on top.
              value_d = value_q << {(4'd8 - cnt_q[3:0]), 3'b000};
            end
          end
          brq_pkg::CMD_GET, brq_pkg::CMD_PEEK: begin
            if (cnt_fits && (cnt_x <= fill_x)) begin
              ok_d   = 1'b1;
              addr_d = rp_q;
            end
          end
          brq_pkg::CMD_PEEK_AT: begin
            if (off_x < fill_x) begin
              ok_d   = 1'b1;
              n_d    = 4'd1;
              addr_d = brq_pkg::slot(rp_q, PW'(offset_q));
            end
          end
          brq_pkg::CMD_SKIP: begin
            ok_d = 1'b1;
            if (cnt_x <= fill_x) begin
              rp_d = brq_pkg::slot(rp_q, PW'(cnt_q));
            end else begin
              rp_d = wp_q;
            end
          end
          brq_pkg::CMD_CLEAR: begin
            ok_d = 1'b1;
            rp_d = '0;
            wp_d = '0;
          end
          default: begin
            ok_d = 1'b0;
          end
        endcase
      end
      brq_pkg::ST_WRITE: begin
        ram_we  = 1'b1;
        value_d = value_q << BW;
        addr_d  = brq_pkg::slot(addr_q, PW'(1));
        idx_d   = idx_q + 3'd1;
        if (last_byte) begin
          wp_d = brq_pkg::slot(addr_q, PW'(1));
        end
      end
      brq_pkg::ST_READ: begin
        rd_pend_d = 1'b1;
        addr_d    = brq_pkg::slot(addr_q, PW'(1));
        idx_d     = idx_q + 3'd1;
      end
      brq_pkg::ST_DRAIN: begin
        // addr_q now points just past the last byte read.
        if (cmd_q == brq_pkg::CMD_GET) begin
          rp_d = addr_q;
        end
      end
      brq_pkg::ST_OUTPUT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= brq_pkg::ST_IDLE;
      rp_q      <= '0;
      wp_q      <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rp_q      <= rp_d;
      wp_q      <= wp_d;
      rd_pend_q <= rd_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == brq_pkg::ST_IDLE) && in_valid_i) begin
      cmd_q    <= command_i;
      cnt_q    <= count_i;
      offset_q <= offset_i;
    end
    value_q <= value_d;
    addr_q  <= addr_d;
    idx_q   <= idx_d;
    n_q     <= n_d;
    acc_q   <= acc_d;
    ok_q    <= ok_d;
  end

  brq_ram #(
    .WIDTH (BW),
    .DEPTH (brq_pkg::DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (value_q[VW-1 -: BW]),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  // Handshake and result fields; the result registers hold while stalled.
  assign in_stall_o   = (state_q != brq_pkg::ST_IDLE);
  assign out_valid_o  = (state_q == brq_pkg::ST_OUTPUT);
  assign ok_o         = ok_q;
  assign data_o       = acc_q;
  assign fill_level_o = brq_pkg::CNT_W'(fill);
  assign space_left_o = brq_pkg::CNT_W'(space);

  // A failed transaction reports no data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !ok_o) |-> (data_o == '0))
    else $error("failed transaction returned nonzero data");

  // A refused command leaves both pointers where they were.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == brq_pkg::ST_DECIDE) && !ok_d) |=> ($stable(rp_q) && $stable(wp_q)))
    else $error("refused command moved a pointer");

  // Read bytes arrive only while the read loop or its drain is running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> ((state_q == brq_pkg::ST_READ) || (state_q == brq_pkg::ST_DRAIN)))
    else $error("read data arrived outside the read loop");

  // The queue is never driven past its usable capacity by a write.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == brq_pkg::ST_WRITE) |-> (space != '0))
    else $error("write into a full queue");

endmodule

/* src/brq_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module brq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* tb/byte_ring_queue_big_endian_tb.sv */
// Self-checking testbench for the big-endian byte ring queue.
`timescale 1ns / 1ps

module byte_ring_queue_big_endian_tb;

  // Command codes six and seven have no operation behind them; the block must
  // answer them with a failure and leave the queue alone.
  localparam logic [brq_pkg::CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [brq_pkg::CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  // The queue keeps one slot empty, so this is the most it can hold.
  localparam int unsigned CAPACITY = brq_pkg::DEPTH - 1;

  // Random transactions per idling phase, and the number of idling phases.
  localparam int unsigned ITEMS_PER_PHASE = 275;
  localparam int unsigned PHASES = 4;

  // The drain wait covers an eight-byte get with margin.
  localparam int unsigned DRAIN_CYCLES = 40;

  // Roughly 1125 transactions, stretched by the cycles lost to sender gaps and
  // receiver stalls, then taken many times over.
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [brq_pkg::CMD_W-1:0] command;
    logic [brq_pkg::CNT_W-1:0] count;
    logic [brq_pkg::VAL_W-1:0] value;
    logic [brq_pkg::CNT_W-1:0] offset;
  } request_t;

  typedef struct packed {
    logic                      ok;
    logic [brq_pkg::VAL_W-1:0] data;
    logic [brq_pkg::CNT_W-1:0] fill_level;
    logic [brq_pkg::CNT_W-1:0] space_left;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // Input channel, driven by the request driver below.
  logic                      in_valid = 1'b0;
  logic                      in_stall_o;
  logic [brq_pkg::CMD_W-1:0] command_i = '0;
  logic [brq_pkg::CNT_W-1:0] count_i = '0;
  logic [brq_pkg::VAL_W-1:0] value_i = '0;
  logic [brq_pkg::CNT_W-1:0] offset_i = '0;

  // Result channel, stalled at random by the answer monitor below.
  logic                      out_valid_o;
  logic                      result_stall = 1'b0;
  logic                      ok_o;
  logic [brq_pkg::VAL_W-1:0] data_o;
  logic [brq_pkg::CNT_W-1:0] fill_level_o;
  logic [brq_pkg::CNT_W-1:0] space_left_o;

  byte_ring_queue_big_endian u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .count_i      (count_i),
    .value_i      (value_i),
    .offset_i     (offset_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (result_stall),
    .ok_o         (ok_o),
    .data_o       (data_o),
    .fill_level_o (fill_level_o),
    .space_left_o (space_left_o)
  );

  // Transactions waiting to be offered, and answers waiting to come back.
  request_t pending_requests[$];
  answer_t  awaited_answers[$];

  // Shadow copy of the queue contents and pointers. Only slots between head
  // and tail are ever read, and every one of those was written by a put.
  logic [7:0]  shadow_bytes [brq_pkg::DEPTH];
  int unsigned head_slot = 0;
  int unsigned tail_slot = 0;

  // Idling knobs, in percent of cycles, set per phase by the sequencer.
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;

  // The random part sweeps the queue from empty to full and back: while
  // heading_full is set the mix favors puts, otherwise gets and skips.
  bit heading_full = 1'b1;

  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic int unsigned bytes_held();
    return (tail_slot + brq_pkg::DEPTH - head_slot) % brq_pkg::DEPTH;
  endfunction

  // Runs one transaction against the shadow queue and returns the answer the
  // block owes for it. Failures leave the shadow state untouched.
  function automatic answer_t shadow_execute(input request_t req);
    answer_t     ans;
    int unsigned held;
    int unsigned n;
    ans = '0;
    held = bytes_held();
    n = 32'(req.count);
    case (req.command)
      brq_pkg::CMD_PUT: begin
        if (n <= brq_pkg::MAX_MOVE && n <= CAPACITY - held) begin
          // The first byte sent is the most significant of the low n bytes.
          for (int i = 0; i < n; i++) begin
            shadow_bytes[brq_pkg::PTR_W'((tail_slot + i) % brq_pkg::DEPTH)] =
              req.value[8*(n-1-i) +: 8];
          end
          tail_slot = (tail_slot + n) % brq_pkg::DEPTH;
          ans.ok = 1'b1;
        end
      end
      brq_pkg::CMD_GET, brq_pkg::CMD_PEEK: begin
        if (n <= brq_pkg::MAX_MOVE && n <= held) begin
          for (int i = 0; i < n; i++) begin
            ans.data = {ans.data[brq_pkg::VAL_W-9:0],
                        shadow_bytes[brq_pkg::PTR_W'((head_slot + i) % brq_pkg::DEPTH)]};
          end
          if (req.command == brq_pkg::CMD_GET) begin
            head_slot = (head_slot + n) % brq_pkg::DEPTH;
          end
          ans.ok = 1'b1;
        end
      end
      brq_pkg::CMD_PEEK_AT: begin
        if (req.offset < held) begin
          ans.data = {56'd0,
                      shadow_bytes[brq_pkg::PTR_W'((head_slot + req.offset) % brq_pkg::DEPTH)]};
          ans.ok = 1'b1;
        end
      end
      brq_pkg::CMD_SKIP: begin
        // Skipping more than is stored simply empties the queue.
        head_slot = (n <= held) ? (head_slot + n) % brq_pkg::DEPTH : tail_slot;
        ans.ok = 1'b1;
      end
      brq_pkg::CMD_CLEAR: begin
        head_slot = 0;
        tail_slot = 0;
        ans.ok = 1'b1;
      end
      default: begin
      end
    endcase
    held = bytes_held();
    ans.fill_level = brq_pkg::CNT_W'(held);
    ans.space_left = brq_pkg::CNT_W'(CAPACITY - held);
    return ans;
  endfunction

  task automatic push_request(input logic [brq_pkg::CMD_W-1:0] command,
                              input int unsigned count,
                              input logic [brq_pkg::VAL_W-1:0] value,
                              input int unsigned offset);
    request_t req;
    req.command = command;
    req.count = brq_pkg::CNT_W'(count);
    req.value = value;
    req.offset = brq_pkg::CNT_W'(offset);
    pending_requests.push_back(req);
  endtask

  // Builds one random transaction shaped by the current shadow fill level.
  task automatic push_random_request();
    int unsigned held;
    int unsigned pick;
    int unsigned count;
    int unsigned offset;
    logic [brq_pkg::CMD_W-1:0] command;
    held = bytes_held();
    if (heading_full && (held == CAPACITY ||
        (held > CAPACITY - 24 && $urandom_range(15) == 0))) begin
      heading_full = 1'b0;
    end else if (!heading_full && (held == 0 || (held < 24 && $urandom_range(15) == 0))) begin
      heading_full = 1'b1;
    end

    // Mostly legal counts, with full eight-byte moves favored while filling so
    // that the queue actually reaches its capacity; now and then any count.
    if ($urandom_range(99) < 15) begin
      count = $urandom_range(1023);
    end else if (heading_full && $urandom_range(99) < 40) begin
      count = brq_pkg::MAX_MOVE;
    end else begin
      count = $urandom_range(brq_pkg::MAX_MOVE);
    end

    // Offsets mostly land on stored bytes or just past the last one.
    offset = ($urandom_range(99) < 60) ? $urandom_range(held) : $urandom_range(1023);

    pick = $urandom_range(99);
    if (heading_full) begin
      if (pick < 60) command = brq_pkg::CMD_PUT;
      else if (pick < 70) command = brq_pkg::CMD_GET;
      else if (pick < 78) command = brq_pkg::CMD_PEEK;
      else if (pick < 90) command = brq_pkg::CMD_PEEK_AT;
      else if (pick < 96) command = brq_pkg::CMD_SKIP;
      else if (pick < 97) command = brq_pkg::CMD_CLEAR;
      else if (pick < 98) command = $urandom_range(1) ? CMD_SPARE_HI : CMD_SPARE_LO;
      else command = brq_pkg::CMD_PEEK;
    end else begin
      if (pick < 15) command = brq_pkg::CMD_PUT;
      else if (pick < 50) command = brq_pkg::CMD_GET;
      else if (pick < 62) command = brq_pkg::CMD_PEEK;
      else if (pick < 80) command = brq_pkg::CMD_PEEK_AT;
      else if (pick < 96) command = brq_pkg::CMD_SKIP;
      else if (pick < 98) command = brq_pkg::CMD_CLEAR;
      else if (pick < 99) command = $urandom_range(1) ? CMD_SPARE_HI : CMD_SPARE_LO;
      else command = brq_pkg::CMD_PUT;
    end
    push_request(command, count, {$urandom, $urandom}, offset);
  endtask

  task automatic report_mismatch(input string what, input logic [brq_pkg::VAL_W-1:0] want,
                                 input logic [brq_pkg::VAL_W-1:0] got);
    $display("[%0t] MISMATCH %s: expected %h, got %h", $realtime, what, want, got);
    mismatches++;
  endtask

  // Request driver. A transaction is taken by the block at an edge where valid
  // is high and stall is low; at that edge its answer is predicted, and the
  // next pending transaction (or a gap) is put on the channel. A stalled
  // payload is never touched.
  always @(posedge clk_i) begin : request_driver
    request_t nxt;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall_o) begin
        awaited_answers.push_back(shadow_execute({command_i, count_i, value_i, offset_i}));
      end
      if (!in_valid || !in_stall_o) begin
        if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_requests.pop_front();
          command_i <= nxt.command;
          count_i <= nxt.count;
          value_i <= nxt.value;
          offset_i <= nxt.offset;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Answer monitor. Every accepted result is checked field by field against
  // the oldest predicted answer; the stall for the next edge is drawn here.
  always @(posedge clk_i) begin : answer_monitor
    answer_t want;
    if (!rst_ni) begin
      result_stall <= 1'b0;
    end else begin
      if (out_valid_o && !result_stall) begin
        if (awaited_answers.size() == 0) begin
          report_mismatch("result with no transaction outstanding", '0, data_o);
        end else begin
          want = awaited_answers.pop_front();
          if (ok_o !== want.ok) begin
            report_mismatch("ok", brq_pkg::VAL_W'(want.ok), brq_pkg::VAL_W'(ok_o));
          end
          if (data_o !== want.data) report_mismatch("data", want.data, data_o);
          if (fill_level_o !== want.fill_level) begin
            report_mismatch("fill_level", brq_pkg::VAL_W'(want.fill_level),
                            brq_pkg::VAL_W'(fill_level_o));
          end
          if (space_left_o !== want.space_left) begin
            report_mismatch("space_left", brq_pkg::VAL_W'(want.space_left),
                            brq_pkg::VAL_W'(space_left_o));
          end
        end
      end
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Sequencer: reset, a directed opening, then the random sweeps under each
  // idling phase, and finally the drain and the verdict.
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty queue: get fails, a zero-byte peek succeeds, peek at offset fails.
    push_request(brq_pkg::CMD_GET, 1, {$urandom, $urandom}, $urandom_range(1023));
    push_request(brq_pkg::CMD_PEEK, 0, {$urandom, $urandom}, $urandom_range(1023));
    push_request(brq_pkg::CMD_PEEK_AT, $urandom_range(1023), {$urandom, $urandom}, 0);
    // Zero-byte put succeeds; counts above eight fail whatever the space.
    push_request(brq_pkg::CMD_PUT, 0, '1, $urandom_range(1023));
    push_request(brq_pkg::CMD_PUT, 9, {$urandom, $urandom}, $urandom_range(1023));
    push_request(brq_pkg::CMD_PUT, 1023, '1, 1023);
    // Four puts leave 27 bytes with known, order-revealing content.
    push_request(brq_pkg::CMD_PUT, 8, 64'h0123_4567_89ab_cdef, $urandom_range(1023));
    push_request(brq_pkg::CMD_PUT, 8, '1, $urandom_range(1023));
    push_request(brq_pkg::CMD_PUT, 3, 64'ha5a5_5a5a_a5a5_5a5a, $urandom_range(1023));
    push_request(brq_pkg::CMD_PUT, 8, '0, $urandom_range(1023));
    push_request(brq_pkg::CMD_PEEK, 8, {$urandom, $urandom}, $urandom_range(1023));
    // Peek at the last stored byte, one past it, and the largest offset.
    push_request(brq_pkg::CMD_PEEK_AT, $urandom_range(1023), {$urandom, $urandom}, 26);
    push_request(brq_pkg::CMD_PEEK_AT, $urandom_range(1023), {$urandom, $urandom}, 27);
    push_request(brq_pkg::CMD_PEEK_AT, $urandom_range(1023), {$urandom, $urandom}, 1023);
    push_request(brq_pkg::CMD_GET, 9, {$urandom, $urandom}, $urandom_range(1023));
    push_request(brq_pkg::CMD_GET, 8, {$urandom, $urandom}, $urandom_range(1023));
    push_request(brq_pkg::CMD_GET, 0, {$urandom, $urandom}, $urandom_range(1023));
    push_request(brq_pkg::CMD_PEEK, 1023, {$urandom, $urandom}, $urandom_range(1023));
    // Unused command codes must change nothing.
    push_request(CMD_SPARE_LO, $urandom_range(8), {$urandom, $urandom}, 0);
    push_request(CMD_SPARE_HI, $urandom_range(8), {$urandom, $urandom}, 0);
    // A short skip, then one far past the fill that empties the queue.
    push_request(brq_pkg::CMD_SKIP, 2, {$urandom, $urandom}, $urandom_range(1023));
    push_request(brq_pkg::CMD_SKIP, 1023, {$urandom, $urandom}, $urandom_range(1023));
    // Clear with data stored, then refill from slot zero.
    push_request(brq_pkg::CMD_PUT, 5, {$urandom, $urandom}, $urandom_range(1023));
    push_request(brq_pkg::CMD_CLEAR, $urandom_range(1023), {$urandom, $urandom},
                 $urandom_range(1023));
    push_request(brq_pkg::CMD_PUT, 2, {$urandom, $urandom}, $urandom_range(1023));

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 49; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 49; end
        default: begin send_idle_pct = 29; stall_pct = 29; end
      endcase
      // Generate just ahead of the driver so the mix follows the fill level.
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        while (pending_requests.size() >= 2) @(negedge clk_i);
        push_random_request();
      end
    end

    while (pending_requests.size() > 0 || in_valid || awaited_answers.size() > 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* byte_ring_queue_big_endian.f */
src/brq_pkg.sv
src/brq_ram.sv
src/byte_ring_queue_big_endian.sv
tb/byte_ring_queue_big_endian_tb.sv
